@@ rtl/stepper_reply_frame_parser_core_macros.svh @@
// ----------------------------------------------------------------------------
// stepper reply frame parser assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef STEPPER_REPLY_FRAME_PARSER_CORE_MACROS_SVH
`define STEPPER_REPLY_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SRFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SRFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/srfp_pkg.sv @@
// ----------------------------------------------------------------------------
// srfp_pkg
// types and constants of the stepper reply frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package srfp_pkg;

    // parse mode codes
    localparam logic [1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [1:0] MODE_ENCODER = 2'd1;

    // shared parse state codes
    localparam logic [2:0] ST_FIRST  = 3'd0;
    localparam logic [2:0] ST_SECOND = 3'd1;
    localparam logic [2:0] ST_THIRD  = 3'd2;
    localparam logic [2:0] ST_VAL3   = 3'd3;
    localparam logic [2:0] ST_VAL2   = 3'd4;
    localparam logic [2:0] ST_VAL1   = 3'd5;
    localparam logic [2:0] ST_VAL0   = 3'd6;

    // byte values
    localparam logic [7:0] BYTE_ARR0   = 8'hFD;
    localparam logic [7:0] BYTE_ARR1   = 8'h9F;
    localparam logic [7:0] BYTE_ARR2   = 8'h6B;
    localparam logic [7:0] BYTE_FUNC   = 8'h36;
    localparam logic [7:0] BYTE_POS    = 8'h00;
    localparam logic [7:0] BYTE_NEG    = 8'h01;
    localparam logic [7:0] BYTE_ID_MIN = 8'h01;
    localparam logic [7:0] BYTE_ID_MAX = 8'h04;

    typedef struct packed {
        logic [2:0] state;
        logic [1:0] motor_sel;
        logic       negate;
    } t_parse_ctl;

    typedef struct packed {
        logic               arrival_seen;
        logic               position_valid;
        logic [1:0]         motor_index;
        logic signed [31:0] position_value;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/srfp_step.sv @@
// ----------------------------------------------------------------------------
// srfp_step
// per-byte next-state and result logic of the reply parser
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_step (
    input  srfp_pkg::t_parse_ctl i_ctl,
    input  logic [31:8]          i_accum,
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_byte,
    output srfp_pkg::t_parse_ctl o_ctl,
    output logic [31:8]          o_accum,
    output srfp_pkg::t_result    o_res
);
    import srfp_pkg::*;

    logic [31:0] w_full;

    assign w_full = {i_accum, i_byte};

    always_comb begin
        o_ctl   = i_ctl;
        o_accum = i_accum;
        o_res   = '0;
        case (i_mode)
            MODE_ARRIVAL: begin
                case (i_ctl.state)
                    ST_FIRST: begin
                        if (i_byte == BYTE_ARR0) o_ctl.state = ST_SECOND;
                    end
                    ST_SECOND: begin
                        if (i_byte == BYTE_ARR1) o_ctl.state = ST_THIRD;
                    end
                    ST_THIRD: begin
                        if (i_byte == BYTE_ARR2) begin
                            o_ctl.state        = ST_FIRST;
                            o_res.arrival_seen = 1'b1;
                        end
                    end
                    default: o_ctl.state = ST_FIRST;
                endcase
            end
            MODE_ENCODER: begin
                case (i_ctl.state)
                    ST_FIRST: begin
                        if (i_byte inside {[BYTE_ID_MIN:BYTE_ID_MAX]}) begin
                            o_ctl.motor_sel = i_byte[1:0] - 2'd1;
                            o_ctl.state     = ST_SECOND;
                        end
                    end
                    ST_SECOND: begin
                        if (i_byte == BYTE_FUNC) o_ctl.state = ST_THIRD;
                    end
                    ST_THIRD: begin
                        if (i_byte == BYTE_NEG) begin
                            o_ctl.negate = 1'b1;
                            o_ctl.state  = ST_VAL3;
                        end else if (i_byte == BYTE_POS) begin
                            o_ctl.negate = 1'b0;
                            o_ctl.state  = ST_VAL3;
                        end
                    end
                    ST_VAL3: begin
                        o_accum     = {i_byte, 16'd0};
                        o_ctl.state = ST_VAL2;
                    end
                    ST_VAL2: begin
                        o_accum[23:16] = i_byte;
                        o_ctl.state    = ST_VAL1;
                    end
                    ST_VAL1: begin
                        o_accum[15:8] = i_byte;
                        o_ctl.state   = ST_VAL0;
                    end
                    ST_VAL0: begin
                        o_res.position_valid = 1'b1;
                        o_res.motor_index    = i_ctl.motor_sel;
                        o_res.position_value = i_ctl.negate ? (32'd0 - w_full) : w_full;
                        o_ctl.state          = ST_FIRST;
                    end
                    default: o_ctl.state = ST_FIRST;
                endcase
            end
            default: o_ctl.state = ST_FIRST;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/stepper_reply_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// stepper_reply_frame_parser_core
// result: registered, valid on the output side in the cycle after byte acceptance
// throughput: one byte per cycle while the result side is not stalled, set by the single output result register
// reset: synchronous active-low, clears parse state, mode and output valid
// the value accumulator is not reset, it is always loaded before it is read
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_reply_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel (parse mode)
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_parse_mode,
    // received byte channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_arrival_seen,
    output logic        o_position_valid,
    output logic [1:0]  o_motor_index,
    output logic signed [31:0] o_position_value
);
    import srfp_pkg::*;

    // mode register
    logic [1:0]  r_parse_mode;

    // parse state shared by both modes
    t_parse_ctl  r_ctl;
    t_parse_ctl  n_ctl;
    // upper three value bytes, the last byte goes straight into the result
    logic [31:8] r_accum;
    logic [31:8] n_accum;

    // output result register
    logic        r_res_valid;
    t_result     r_res;
    t_result     n_res;

    logic        w_rx_take;

    // the user must make config writes land only while idle; the block does not enforce it, the port is always open
    assign o_cfg_ready = 1'b1;

    // a new byte goes in whenever the result register is empty or draining
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign w_rx_take  = i_rx_valid && o_rx_ready;

    srfp_step u_step (
        .i_ctl   (r_ctl),
        .i_accum (r_accum),
        .i_mode  (r_parse_mode),
        .i_byte  (i_rx_byte),
        .o_ctl   (n_ctl),
        .o_accum (n_accum),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_mode <= MODE_ARRIVAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_parse_mode <= i_cfg_parse_mode;
        end
    end

    // control state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (w_rx_take) begin
            r_ctl <= n_ctl;
        end
    end

    // accumulator payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_rx_take) begin
            r_accum <= n_accum;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_rx_take) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // result payload, loaded with every accepted byte
    always_ff @(posedge i_clk) begin
        if (w_rx_take) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_arrival_seen   = r_res.arrival_seen;
    assign o_position_valid = r_res.position_valid;
    assign o_motor_index    = r_res.motor_index;
    assign o_position_value = r_res.position_value;

endmodule

`default_nettype wire

@@ rtl/srfp_checker.sv @@
// ----------------------------------------------------------------------------
// srfp_checker
// port-level checks of the stepper reply frame parser
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_reply_frame_parser_core_macros.svh"

module srfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        o_rx_ready,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic        o_arrival_seen,
    input logic        o_position_valid,
    input logic [1:0]  o_motor_index,
    input logic [31:0] o_position_value
);

    // every accepted byte yields a result in the next cycle
    `SRFP_ASSERT_NEXT(a_item_to_result, i_clk, i_rst_n, i_rx_valid && o_rx_ready, o_res_valid, "accepted item gave no result")

    // stalled result holds
    `SRFP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid && $stable(o_position_value) && $stable(o_arrival_seen), "stalled result changed")

    // a byte finishes at most one kind of sequence
    `SRFP_ASSERT_NOW(a_one_event, i_clk, i_rst_n, o_res_valid, !(o_arrival_seen && o_position_valid), "arrival and frame together")

    // fields are zero unless a frame completed
    `SRFP_ASSERT_NOW(a_zero_fields, i_clk, i_rst_n, o_res_valid && !o_position_valid, (o_motor_index == 2'd0) && (o_position_value == 32'd0), "idle result fields not zero")

endmodule

bind stepper_reply_frame_parser_core srfp_checker u_srfp_checker (.*);

`default_nettype wire
